[rtl/core/kcc_pkg.sv]
`timescale 1ns / 1ps

package kcc_pkg;

    localparam int NUM_KEYS_DEF = 4;

    localparam int KEY_W    = 2;
    localparam int LEVEL_W  = 1;
    localparam int TIMER_W  = 8;
    localparam int TALLY_W  = 2;
    localparam int MASK_W   = 4;
    localparam int EVENT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_W    = 8;

    localparam logic [TIMER_W-1:0] LONG_TICKS_RST = 8'd60;
    localparam logic [TIMER_W-1:0] DBL_TICKS_RST  = 8'd20;
    localparam logic [MASK_W-1:0]  ACTIVE_MASK_RST = 4'd8;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_TICKS  = 2'd0,
        REG_DBL_TICKS   = 2'd1,
        REG_ACTIVE_MASK = 2'd2
    } t_cfg_reg;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'b0001,
        MODE_PRESSED  = 4'b0010,
        MODE_RELEASED = 4'b0100,
        MODE_WAIT     = 4'b1000
    } t_key_mode;

endpackage

[rtl/core/key_click_classifier_top.sv]
`timescale 1ns / 1ps

// path: an accepted item passes the input register, then the result register (loaded when free or being taken)
// throughput: one item per cycle while the master side takes results; the per-key state
// read-modify-write is combinational between the input register and the result register
// reset: synchronous, active low; clears the key machines, the last-event
// register, both valid flags and loads the configuration defaults
module key_click_classifier_top #(
    parameter int NUM_KEYS = kcc_pkg::NUM_KEYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side; tdata: [1:0] key, [2] pin_level, [7:3] zero
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [kcc_pkg::TDATA_W-1:0]      i_s_axis_tdata,
    // master side; tdata: [1:0] event_key, [3:2] event_code, [7:4] zero
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [kcc_pkg::TDATA_W-1:0]      o_m_axis_tdata,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import kcc_pkg::*;

    localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [TIMER_W-1:0] r_long_ticks;
    logic [TIMER_W-1:0] r_dbl_ticks;
    logic [MASK_W-1:0]  r_active_mask;

    logic               r_in_valid;
    logic [KEY_W-1:0]   r_in_key;
    logic               r_in_level;

    t_key_mode          r_mode  [NUM_KEYS];
    logic [TIMER_W-1:0] r_timer [NUM_KEYS];
    logic [TALLY_W-1:0] r_tally [NUM_KEYS];
    t_event             r_last;

    logic               r_out_valid;
    logic [KEY_W-1:0]   r_out_key;
    t_event             r_out_code;

    logic               w_adv;
    logic               w_step;
    logic               w_in_range;
    logic [KEY_IDX_W-1:0] w_kidx;
    logic               w_pressed;
    t_key_mode          w_mode;
    logic [TIMER_W-1:0] w_timer;
    logic [TIMER_W-1:0] w_timer_inc;
    logic [TALLY_W-1:0] w_tally;
    t_key_mode          n_mode;
    logic [TIMER_W-1:0] n_timer;
    logic [TALLY_W-1:0] n_tally;
    t_event             w_event;
    t_event             n_last;
    t_event             n_code;

    // result register free or being taken this cycle
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_step          = w_adv && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(TDATA_W - KEY_W - EVENT_W){1'b0}}, r_out_code, r_out_key};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks  <= LONG_TICKS_RST;
            r_dbl_ticks   <= DBL_TICKS_RST;
            r_active_mask <= ACTIVE_MASK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LONG_TICKS:  r_long_ticks  <= i_cfg_data;
                REG_DBL_TICKS:   r_dbl_ticks   <= i_cfg_data;
                REG_ACTIVE_MASK: r_active_mask <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_key   <= i_s_axis_tdata[KEY_W-1:0];
            r_in_level <= i_s_axis_tdata[KEY_W];
        end
    end

    // per-key machine
    assign w_in_range  = int'(r_in_key) < NUM_KEYS;
    assign w_kidx      = KEY_IDX_W'(r_in_key);
    assign w_pressed   = (r_in_level == r_active_mask[r_in_key]);
    assign w_mode      = r_mode[w_kidx];
    assign w_timer     = r_timer[w_kidx];
    assign w_tally     = r_tally[w_kidx];
    assign w_timer_inc = (w_timer == TIMER_MAX) ? TIMER_MAX : w_timer + 1'b1;

    always_comb begin
        n_mode  = w_mode;
        n_timer = w_timer;
        n_tally = w_tally;
        w_event = EV_NONE;
        unique case (w_mode)
            MODE_IDLE: begin
                if (w_pressed) begin
                    n_mode  = MODE_PRESSED;
                    n_timer = '0;
                end
            end
            MODE_PRESSED: begin
                if (w_pressed) begin
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= r_long_ticks) begin
                        w_event = EV_LONG;
                        n_mode  = MODE_IDLE;
                        n_tally = '0;
                        n_timer = '0;
                    end
                end else if (w_timer < r_long_ticks) begin
                    n_mode = MODE_RELEASED;
                    if (w_tally != TALLY_MAX) begin
                        n_tally = w_tally + 1'b1;
                    end
                end else begin
                    n_mode  = MODE_IDLE;
                    n_tally = '0;
                    n_timer = '0;
                end
            end
            MODE_RELEASED: begin
                if (w_tally == TALLY_W'(1)) begin
                    n_mode  = MODE_WAIT;
                    n_timer = '0;
                end else if (w_tally == TALLY_W'(2)) begin
                    w_event = EV_DOUBLE;
                    n_mode  = MODE_IDLE;
                    n_tally = '0;
                end else begin
                    n_mode  = MODE_IDLE;
                    n_tally = '0;
                end
            end
            MODE_WAIT: begin
                n_timer = w_timer_inc;
                if (w_timer_inc >= r_dbl_ticks) begin
                    w_event = EV_SINGLE;
                    n_mode  = MODE_IDLE;
                    n_tally = '0;
                end else if (w_pressed) begin
                    n_mode  = MODE_PRESSED;
                    n_timer = '0;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase
    end

    // single click right after a long press is dropped and leaves r_last alone
    always_comb begin
        n_last = r_last;
        n_code = EV_NONE;
        if (w_in_range && w_event != EV_NONE &&
            !(r_last == EV_LONG && w_event == EV_SINGLE)) begin
            n_last = w_event;
            n_code = w_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_mode[k]  <= MODE_IDLE;
                r_timer[k] <= '0;
                r_tally[k] <= '0;
            end
            r_last <= EV_NONE;
        end else if (w_step) begin
            if (w_in_range) begin
                r_mode[w_kidx]  <= n_mode;
                r_timer[w_kidx] <= n_timer;
                r_tally[w_kidx] <= n_tally;
            end
            r_last <= n_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_key  <= r_in_key;
            r_out_code <= n_code;
        end
    end

endmodule

[rtl/core/kcc_checker.sv]
`timescale 1ns / 1ps

module kcc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [kcc_pkg::TDATA_W-1:0] o_m_axis_tdata
);
    import kcc_pkg::*;

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // with nothing waiting on the master side the input is never held off
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

    // an accepted item shows up once the result register is free
    a_item_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) ##1 !o_m_axis_tvalid |=> o_m_axis_tvalid)
        else $error("accepted item did not reach the result register");

endmodule

bind key_click_classifier_top kcc_checker u_kcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
